// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned PayloadW = 7;
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // kind of byte, decided without looking at the decoder state
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef struct packed {
    byte_cls_e             cls;
    logic [PayloadW-1:0]   payload;
    logic                  last;
  } cls_item_t;

  typedef struct packed {
    logic [CpW-1:0] uchar;
    logic           has_uchar;
    logic           replaced;
    logic           end_of_text;
  } result_t;

  localparam int unsigned ClsItemW = $bits(cls_item_t);
  localparam int unsigned ResultW = $bits(result_t);

endpackage

// ----- src/utf8d_fifo.sv -----
module utf8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/utf8d_front.sv -----
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       item_push_o,
  output cls_item_t  item_o
);

  assign item_push_o = push_i & ~full_i;

  // sort the byte by its leading bits and strip the marker bits
  always_comb begin
    item_o.last = last_byte_i;
    if (!data_byte_i[7]) begin
      item_o.cls     = CLS_ASCII;
      item_o.payload = data_byte_i[6:0];
    end else if (data_byte_i[7:6] == 2'b10) begin
      item_o.cls     = CLS_CONT;
      item_o.payload = {1'b0, data_byte_i[5:0]};
    end else if (data_byte_i[7:5] == 3'b110) begin
      item_o.cls     = CLS_LEAD2;
      item_o.payload = {2'b00, data_byte_i[4:0]};
    end else if (data_byte_i[7:4] == 4'b1110) begin
      item_o.cls     = CLS_LEAD3;
      item_o.payload = {3'b000, data_byte_i[3:0]};
    end else if (data_byte_i[7:3] == 5'b11110) begin
      item_o.cls     = CLS_LEAD4;
      item_o.payload = {4'b0000, data_byte_i[2:0]};
    end else begin
      item_o.cls     = CLS_BAD;
      item_o.payload = '0;
    end
  end

endmodule

// ----- src/utf8d_back.sv -----
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  cls_item_t item_i,
  output logic      item_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output result_t   res_o
);

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     pend_q, pend_d;
  logic [CpW-1:0] acc_shift;
  logic [1:0]     pend_dec;
  logic           emit;

  assign item_pop_o = item_valid_i & ~res_full_i;
  assign res_push_o = item_pop_o & emit;
  assign acc_shift  = {acc_q[CpW-7:0], item_i.payload[5:0]};
  assign pend_dec   = pend_q - 2'd1;

  always_comb begin
    acc_d = acc_q;
    pend_d = pend_q;
    emit = 1'b0;
    res_o = '{uchar: '0, has_uchar: 1'b0, replaced: 1'b0,
              end_of_text: item_i.last};
    if (pend_q == 2'd0) begin
      case (item_i.cls)
        CLS_ASCII: begin
          emit = 1'b1;
          res_o.uchar = CpW'(item_i.payload);
          res_o.has_uchar = 1'b1;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          acc_d = CpW'(item_i.payload);
          pend_d = (item_i.cls == CLS_LEAD2) ? 2'd1 :
                   (item_i.cls == CLS_LEAD3) ? 2'd2 : 2'd3;
          // truncated at end of text: hand out what was loaded
          emit = item_i.last;
          res_o.uchar = CpW'(item_i.payload);
          res_o.has_uchar = 1'b1;
        end
        default: begin
          // drop stray continuation or illegal lead; mark end only
          emit = item_i.last;
        end
      endcase
    end else if (item_i.cls != CLS_CONT) begin
      // abandon the sequence and consume the byte
      acc_d = '0;
      pend_d = '0;
      emit = 1'b1;
      res_o.uchar = Replacement;
      res_o.has_uchar = 1'b1;
      res_o.replaced = 1'b1;
    end else begin
      acc_d = acc_shift;
      pend_d = pend_dec;
      res_o.uchar = acc_shift;
      res_o.has_uchar = 1'b1;
      if (pend_dec == 2'd0 || item_i.last) begin
        emit = 1'b1;
        acc_d = '0;
        pend_d = '0;
      end
    end
    if (item_i.last) begin
      acc_d = '0;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
    end else if (item_pop_o) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ----- src/utf8_decoder.sv -----
// Path: a transferred byte is held in the classifier queue and decoded by the back end;
// its result (if any) is registered in the result queue, which then shows empty low.
// Throughput: one byte per cycle, set by the state update in the back end; a full
// result queue stalls the back end, then the byte queue.
// Reset: asynchronous, clears both queues, the accumulator and pending count.
module utf8_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MidDepth,
  parameter int unsigned OUT_DEPTH = OutDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           empty,
  input  logic           pop,
  output logic [CpW-1:0] uchar_o,
  output logic           has_uchar_o,
  output logic           replaced_o,
  output logic           end_of_text_o
);

  cls_item_t front_item, mid_item;
  logic      front_push, mid_empty, mid_pop;
  logic      res_push, res_full;
  result_t   back_res, out_res;

  utf8d_front u_front (
    .push_i      (push),
    .full_i      (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_push_o (front_push),
    .item_o      (front_item)
  );

  utf8d_fifo #(
    .WIDTH (ClsItemW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~mid_empty),
    .item_i       (mid_item),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  utf8d_fifo #(
    .WIDTH (ResultW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign uchar_o       = out_res.uchar;
  assign has_uchar_o   = out_res.has_uchar;
  assign replaced_o    = out_res.replaced;
  assign end_of_text_o = out_res.end_of_text;

  a_replaced_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && replaced_o |-> has_uchar_o && uchar_o == Replacement)
    else $error("replacement result without 0xFFFD");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !has_uchar_o |-> end_of_text_o && uchar_o == '0)
    else $error("bare result that is not an end marker");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> mid_pop && !mid_empty)
    else $error("result produced without a consumed byte");

  a_marker_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop && mid_item.last |-> res_push && back_res.end_of_text)
    else $error("last byte did not produce an end of text result");

endmodule
